// ===== rtl/emf_pkg.sv =====
package emf_pkg;

	// frame geometry
	localparam int FRAME_WIDTH  = 320;
	localparam int FRAME_HEIGHT = 200;

	// position counter widths
	localparam int COL_W = $clog2(FRAME_WIDTH);
	localparam int ROW_W = $clog2(FRAME_HEIGHT);

	// result field widths
	localparam int PIX_W     = 8;
	localparam int OUT_COL_W = 9;
	localparam int OUT_ROW_W = 8;

	// stream data widths, whole bytes
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_FIELD_W = PIX_W + OUT_COL_W + OUT_ROW_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	// line store entry: upper row in the low byte, middle row in the high byte
	localparam int LINE_W = 2 * PIX_W;

	// result queue, depth must be a power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// one result item
	typedef struct packed {
		logic [OUT_ROW_W-1:0] row;
		logic [OUT_COL_W-1:0] col;
		logic [PIX_W-1:0]     pixel;
		logic                 last;
	} result_t;

endpackage

// ===== rtl/emf_ram.sv =====
module emf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port, read returns old data on collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/emf_front.sv =====
module emf_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [emf_pkg::PIX_W-1:0]   in_pixel,
	input  logic                        in_start,
	input  logic [emf_pkg::QCNT_W-1:0]  q_count,
	output logic                        push,
	output emf_pkg::result_t            push_data
);

	localparam int SUM_W = emf_pkg::PIX_W + 3;

	logic                          acc;
	logic [emf_pkg::COL_W-1:0]     col_q, col_cur, col_nxt;
	logic [emf_pkg::ROW_W-1:0]     row_q, row_cur, row_nxt;

	logic                          valid_s1;
	logic [emf_pkg::PIX_W-1:0]     pix_s1;
	logic [emf_pkg::COL_W-1:0]     col_s1;
	logic [emf_pkg::ROW_W-1:0]     row_s1;
	logic                          fwd_s1;
	logic [emf_pkg::LINE_W-1:0]    fwd_data_s1;

	logic [emf_pkg::LINE_W-1:0]    ram_rdata, line_rd, line_wr;
	logic [emf_pkg::PIX_W-1:0]     top, mid;
	logic [emf_pkg::PIX_W-1:0]     w0_q, w1_q, w2_q, w3_q, w4_q, w5_q;
	logic [SUM_W-1:0]              sum;

	// room for the item in flight plus a new one
	assign in_ready = ({1'b0, q_count} + {{emf_pkg::QCNT_W{1'b0}}, valid_s1})
		< (emf_pkg::QCNT_W+1)'(emf_pkg::QUEUE_DEPTH);
	assign acc = in_valid && in_ready;

	// position of the incoming pixel, frame start forces the origin
	always_comb begin
		col_cur = in_start ? '0 : col_q;
		row_cur = in_start ? '0 : row_q;
		col_nxt = col_cur + 1'b1;
		row_nxt = row_cur;
		if (col_cur == emf_pkg::COL_W'(emf_pkg::FRAME_WIDTH - 1)) begin
			col_nxt = '0;
			if (row_cur == emf_pkg::ROW_W'(emf_pkg::FRAME_HEIGHT - 1)) begin
				row_nxt = '0;
			end else begin
				row_nxt = row_cur + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

	// line store, read at accept, written back in the cycle after
	emf_ram #(
		.WIDTH(emf_pkg::LINE_W),
		.DEPTH(emf_pkg::FRAME_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (valid_s1),
		.waddr(col_s1),
		.wdata(line_wr),
		.re   (acc),
		.raddr(col_cur),
		.rdata(ram_rdata)
	);

	// bypass when the new read hits the entry being written
	assign line_rd = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign top     = line_rd[emf_pkg::PIX_W-1:0];
	assign mid     = line_rd[emf_pkg::LINE_W-1:emf_pkg::PIX_W];
	assign line_wr = {pix_s1, mid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= acc;
			fwd_s1   <= acc && valid_s1 && (col_cur == col_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1 <= in_pixel;
			col_s1 <= col_cur;
			row_s1 <= row_cur;
		end
		fwd_data_s1 <= line_wr;
	end

	// 3x3 window, two past columns of top, middle and bottom
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q <= '0;
			w1_q <= '0;
			w2_q <= '0;
			w3_q <= '0;
			w4_q <= '0;
			w5_q <= '0;
		end else if (valid_s1) begin
			w0_q <= w3_q;
			w1_q <= w4_q;
			w2_q <= w5_q;
			w3_q <= top;
			w4_q <= mid;
			w5_q <= pix_s1;
		end
	end

	// eight neighbours, centre left out
	assign sum = SUM_W'(w0_q) + SUM_W'(w3_q) + SUM_W'(top)
		+ SUM_W'(w1_q) + SUM_W'(mid)
		+ SUM_W'(w2_q) + SUM_W'(w5_q) + SUM_W'(pix_s1);

	// interior centres only
	always_comb begin
		push            = valid_s1 && (col_s1 >= emf_pkg::COL_W'(2))
			&& (row_s1 >= emf_pkg::ROW_W'(2));
		push_data.pixel = sum[SUM_W-1:3];
		push_data.col   = emf_pkg::OUT_COL_W'(col_s1 - 1'b1);
		push_data.row   = emf_pkg::OUT_ROW_W'(row_s1 - 1'b1);
		push_data.last  = (col_s1 == emf_pkg::COL_W'(emf_pkg::FRAME_WIDTH - 1))
			&& (row_s1 == emf_pkg::ROW_W'(emf_pkg::FRAME_HEIGHT - 1));
	end

endmodule

// ===== rtl/emf_queue.sv =====
module emf_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  emf_pkg::result_t           push_data,
	input  logic                       pop,
	output logic                       head_valid,
	output emf_pkg::result_t           head_data,
	output logic [emf_pkg::QCNT_W-1:0] count
);

	emf_pkg::result_t              entry_q [emf_pkg::QUEUE_DEPTH];
	logic [emf_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [emf_pkg::QCNT_W-1:0]    count_q;

	// pointers and fill level, the front never pushes into a full queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign head_valid = (count_q != '0);
	assign head_data  = entry_q[rd_ptr_q];
	assign count      = count_q;

endmodule

// ===== rtl/emf_back.sv =====
module emf_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            head_valid,
	input  emf_pkg::result_t                head_data,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [emf_pkg::OUT_TDATA_W-1:0] out_data,
	output logic                            out_last
);

	logic             valid_q;
	emf_pkg::result_t data_q;

	// reload the output register when empty or when its transfer completes
	assign pop = head_valid && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= head_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = {{(emf_pkg::OUT_TDATA_W - emf_pkg::OUT_FIELD_W){1'b0}},
		data_q.row, data_q.col, data_q.pixel};
	assign out_last  = data_q.last;

endmodule

// ===== rtl/eight_neighbour_mean_filter_top.sv =====
// 3x3 eight-neighbour mean filter for a 320x200 raster stream of 8-bit pixels.
// slave channel: one pixel per transfer in raster order, tuser marks the first
// pixel of a frame and forces the position counters back to the origin.
// master channel: one result per interior centre pixel, carrying the mean of
// its eight neighbours together with the centre's column and row; tlast flags
// the last interior pixel of the frame. border pixels produce nothing.
// a result for centre (c,r) is triggered by the pixel at (c+1,r+1); it passes
// through the s1 registers, the result queue and the output register before
// m_tvalid rises.
// throughput is one pixel per cycle while the queue has room: the line store
// is read at accept and written back the next cycle through its separate write
// port, with a bypass for a read that hits the entry being written.
// a four-entry result queue and an output register decouple the two sides:
// when the receiver stalls, pixels are still taken until the queue plus the
// pixel in flight is full, then s_tready drops until a result is taken.
// reset clears the counters, the window and the queue; the line store is not
// cleared, so no clearing pass is needed and the block is ready at once.
// the first two rows after reset or a frame start produce no results.
module eight_neighbour_mean_filter_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [emf_pkg::IN_TDATA_W-1:0]  s_tdata,  // pixel_in[7:0]
	input  logic                            s_tuser,  // frame_start
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [emf_pkg::OUT_TDATA_W-1:0] m_tdata,  // pixel_out, out_col, out_row, zero pad
	output logic                            m_tlast   // frame_last
);

	logic                       push, pop, head_valid;
	emf_pkg::result_t           push_data, head_data;
	logic [emf_pkg::QCNT_W-1:0] q_count;

	// counters, line store, window and sum
	emf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_pixel (s_tdata[emf_pkg::PIX_W-1:0]),
		.in_start (s_tuser),
		.q_count  (q_count),
		.push     (push),
		.push_data(push_data)
	);

	// result queue
	emf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head_valid(head_valid),
		.head_data (head_data),
		.count     (q_count)
	);

	// output register
	emf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_data (head_data),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule
